### rtl/mcud_pkg.sv
// shared types, constants and digit functions for the mod-60 up/down counter display
package mcud_pkg;

  // count range and widths
  localparam int unsigned MAX_COUNT = 59;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned TICK_W    = 10;
  localparam int unsigned SEG_W     = 7;
  localparam int unsigned BCD_W     = 8;
  localparam int unsigned IDX_W     = 3;

  // register reset values
  localparam logic [TICK_W-1:0] UP_TICKS_RST       = TICK_W'(20);
  localparam logic [TICK_W-1:0] DOWN_TICKS_RST     = TICK_W'(50);
  localparam logic [TICK_W-1:0] BLINK_TICKS_RST    = TICK_W'(500);
  localparam logic [TICK_W-1:0] OVER_ON_TICKS_RST  = TICK_W'(20);
  localparam logic [TICK_W-1:0] OVER_WRAP_RST      = TICK_W'(40);
  localparam logic [TICK_W-1:0] UNDER_ON_TICKS_RST = TICK_W'(50);
  localparam logic [TICK_W-1:0] UNDER_WRAP_RST     = TICK_W'(100);

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_UP_TICKS       = 3'd0,
    CFG_DOWN_TICKS     = 3'd1,
    CFG_BLINK_TICKS    = 3'd2,
    CFG_OVER_ON_TICKS  = 3'd3,
    CFG_OVER_WRAP      = 3'd4,
    CFG_UNDER_ON_TICKS = 3'd5,
    CFG_UNDER_WRAP     = 3'd6
  } cfg_index_t;

  // counter phase
  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_OVER  = 2'd1,
    PH_UNDER = 2'd2
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] up_ticks;
    logic [TICK_W-1:0] down_ticks;
    logic [TICK_W-1:0] blink_ticks;
    logic [TICK_W-1:0] over_on_ticks;
    logic [TICK_W-1:0] over_wrap;
    logic [TICK_W-1:0] under_on_ticks;
    logic [TICK_W-1:0] under_wrap;
  } cfg_t;

  typedef struct packed {
    logic             tens_enable;
    logic             units_enable;
    logic [SEG_W-1:0] segments;
    logic [BCD_W-1:0] bcd_leds;
  } result_t;

  // packed bcd of a value below 100
  function automatic logic [BCD_W-1:0] to_bcd(input logic [CNT_W-1:0] v);
    logic [3:0]       tens;
    logic [CNT_W-1:0] rem;
    tens = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (v >= CNT_W'(10 * i)) begin
        tens = 4'(i);
      end
    end
    rem = v - (CNT_W'(tens) * CNT_W'(10));
    return {tens, rem[3:0]};
  endfunction

  // segment pattern g..a for one decimal digit
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

### rtl/mcud_cfg.sv
// configuration register file for the counter display
module mcud_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [mcud_pkg::IDX_W-1:0]   cfg_index,
  input  logic [mcud_pkg::TICK_W-1:0]  cfg_data,
  output mcud_pkg::cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.up_ticks       <= mcud_pkg::UP_TICKS_RST;
      cfg.down_ticks     <= mcud_pkg::DOWN_TICKS_RST;
      cfg.blink_ticks    <= mcud_pkg::BLINK_TICKS_RST;
      cfg.over_on_ticks  <= mcud_pkg::OVER_ON_TICKS_RST;
      cfg.over_wrap      <= mcud_pkg::OVER_WRAP_RST;
      cfg.under_on_ticks <= mcud_pkg::UNDER_ON_TICKS_RST;
      cfg.under_wrap     <= mcud_pkg::UNDER_WRAP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mcud_pkg::CFG_UP_TICKS:       cfg.up_ticks       <= cfg_data;
        mcud_pkg::CFG_DOWN_TICKS:     cfg.down_ticks     <= cfg_data;
        mcud_pkg::CFG_BLINK_TICKS:    cfg.blink_ticks    <= cfg_data;
        mcud_pkg::CFG_OVER_ON_TICKS:  cfg.over_on_ticks  <= cfg_data;
        mcud_pkg::CFG_OVER_WRAP:      cfg.over_wrap      <= cfg_data;
        mcud_pkg::CFG_UNDER_ON_TICKS: cfg.under_on_ticks <= cfg_data;
        mcud_pkg::CFG_UNDER_WRAP:     cfg.under_wrap     <= cfg_data;
        default: begin
          // unknown index, dropped
        end
      endcase
    end
  end

endmodule

### rtl/mcud_core.sv
// counter, blink sequencer and digit mux state with its per-tick update
module mcud_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                count_down,
  input  mcud_pkg::cfg_t      cfg,
  output mcud_pkg::result_t   result
);

  logic [mcud_pkg::CNT_W-1:0]  count_value, count_value_next;
  mcud_pkg::phase_t            phase, phase_next;
  logic [mcud_pkg::TICK_W-1:0] period_tick, period_tick_next;
  logic [mcud_pkg::TICK_W-1:0] blink_cycle, blink_cycle_next;
  logic                        latched_down, latched_down_next;
  logic                        digit_select, digit_select_next;
  logic [mcud_pkg::BCD_W-1:0]  bcd_register, bcd_register_next;

  logic                        disp_on;
  logic [mcud_pkg::BCD_W-1:0]  shown;
  logic [mcud_pkg::TICK_W:0]   pt_inc;
  logic [mcud_pkg::TICK_W:0]   bc_inc;
  logic [mcud_pkg::TICK_W-1:0] on_t;
  logic [mcud_pkg::TICK_W-1:0] wrap;
  logic [mcud_pkg::TICK_W-1:0] len;
  logic                        ld_now;
  logic                        over;

  assign pt_inc = {1'b0, period_tick} + 1'b1;
  assign bc_inc = {1'b0, blink_cycle} + 1'b1;
  assign shown  = mcud_pkg::to_bcd(count_value);

  always_comb begin
    count_value_next  = count_value;
    phase_next        = phase;
    period_tick_next  = period_tick;
    blink_cycle_next  = blink_cycle;
    latched_down_next = latched_down;
    digit_select_next = ~digit_select;
    bcd_register_next = bcd_register;
    disp_on           = 1'b1;
    over              = 1'b0;
    on_t              = '0;
    wrap              = '0;
    len               = '0;
    ld_now            = latched_down;

    unique case (phase)
      mcud_pkg::PH_OVER, mcud_pkg::PH_UNDER: begin
        over    = (phase == mcud_pkg::PH_OVER);
        on_t    = over ? cfg.over_on_ticks : cfg.under_on_ticks;
        wrap    = over ? cfg.over_wrap : cfg.under_wrap;
        disp_on = (blink_cycle < on_t);
        blink_cycle_next = (bc_inc > {1'b0, wrap}) ? '0 : bc_inc[mcud_pkg::TICK_W-1:0];
        if (pt_inc >= {1'b0, cfg.blink_ticks}) begin
          count_value_next  = over ? '0 : mcud_pkg::CNT_W'(mcud_pkg::MAX_COUNT);
          bcd_register_next = over ? '0 :
                              mcud_pkg::to_bcd(mcud_pkg::CNT_W'(mcud_pkg::MAX_COUNT));
          phase_next        = mcud_pkg::PH_COUNT;
          period_tick_next  = '0;
        end else begin
          period_tick_next  = pt_inc[mcud_pkg::TICK_W-1:0];
        end
      end
      default: begin
        // counting, and the unused code behaves the same
        phase_next = mcud_pkg::PH_COUNT;
        if (period_tick == '0) begin
          ld_now = count_down;
        end
        latched_down_next = ld_now;
        len = ld_now ? cfg.down_ticks : cfg.up_ticks;
        if (pt_inc >= {1'b0, len}) begin
          period_tick_next = '0;
          if (!ld_now) begin
            if (count_value >= mcud_pkg::CNT_W'(mcud_pkg::MAX_COUNT)) begin
              count_value_next = mcud_pkg::CNT_W'(mcud_pkg::MAX_COUNT);
              phase_next       = mcud_pkg::PH_OVER;
              blink_cycle_next = '0;
            end else begin
              count_value_next  = count_value + 1'b1;
              bcd_register_next = mcud_pkg::to_bcd(count_value + 1'b1);
            end
          end else begin
            if (count_value == '0) begin
              phase_next       = mcud_pkg::PH_UNDER;
              blink_cycle_next = '0;
            end else begin
              count_value_next  = count_value - 1'b1;
              bcd_register_next = mcud_pkg::to_bcd(count_value - 1'b1);
            end
          end
        end else begin
          period_tick_next = pt_inc[mcud_pkg::TICK_W-1:0];
        end
      end
    endcase

    result.tens_enable  = disp_on & ~digit_select;
    result.units_enable = disp_on & digit_select;
    result.segments     = disp_on ?
                          mcud_pkg::seg_pattern(digit_select ? shown[3:0] : shown[7:4]) : '0;
    result.bcd_leds     = bcd_register_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value  <= '0;
      phase        <= mcud_pkg::PH_COUNT;
      period_tick  <= '0;
      blink_cycle  <= '0;
      latched_down <= 1'b0;
      digit_select <= 1'b0;
      bcd_register <= '0;
    end else if (step) begin
      count_value  <= count_value_next;
      phase        <= phase_next;
      period_tick  <= period_tick_next;
      blink_cycle  <= blink_cycle_next;
      latched_down <= latched_down_next;
      digit_select <= digit_select_next;
      bcd_register <= bcd_register_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_value <= mcud_pkg::CNT_W'(mcud_pkg::MAX_COUNT))
    else $error("count above its maximum");

  a_digit_alternates: assert property (@(posedge clk) disable iff (rst)
    step |=> (digit_select != $past(digit_select)))
    else $error("digit select did not alternate on a tick");

  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    (bcd_register[3:0] <= 4'd9) && (bcd_register[7:4] <= 4'd9))
    else $error("bcd led byte holds a non-decimal nibble");

  a_counting_shows_digit: assert property (@(posedge clk) disable iff (rst)
    (step && (phase == mcud_pkg::PH_COUNT)) |-> (result.tens_enable != result.units_enable))
    else $error("counting tick does not drive exactly one digit");
`endif

endmodule

### rtl/mod60_updown_counter_display_core.sv
// top level of the mod-60 up/down counter with muxed seven-segment and bcd led outputs
//
// each word on the tick channel is one timer tick carrying the direction switch
// (count_down); each tick yields exactly one word on the display channel with the
// digit enables, the segment pattern g..a of the driven digit and the packed bcd led
// byte as it stands after that tick. the switch is sampled on the first tick of a
// counting period, which lasts up_ticks or down_ticks ticks, after which the count
// steps within 0..59. stepping past either end holds the count, blinks the display for
// blink_ticks ticks and then loads the opposite end. the block takes one tick per
// clock as long as the display side keeps taking words: a tick word is held in the
// input register, and the state update is a single pass of logic from there into
// the result register. a stall on the display side holds the result register and,
// through it, the input register. configuration writes (cfg_write, cfg_index,
// cfg_data) take effect on the next clock and are meant to be issued while no tick
// is in flight.
module mod60_updown_counter_display_core (
  input  logic                          clk,
  input  logic                          rst,

  // configuration write port
  input  logic                          cfg_write,
  input  logic [mcud_pkg::IDX_W-1:0]    cfg_index,
  input  logic [mcud_pkg::TICK_W-1:0]   cfg_data,

  // tick channel
  input  logic                          tick_valid,
  output logic                          tick_stall,
  input  logic                          count_down,

  // display channel
  output logic                          disp_valid,
  input  logic                          disp_stall,
  output logic                          tens_enable,
  output logic                          units_enable,
  output logic [mcud_pkg::SEG_W-1:0]    segments,
  output logic [mcud_pkg::BCD_W-1:0]    bcd_leds
);

  mcud_pkg::cfg_t    cfg;
  mcud_pkg::result_t result;

  // input register
  logic s1_valid;
  logic s1_count_down;

  logic tick_take;
  logic advance;

  // a held word moves on when the result register is empty or being drained
  assign advance    = s1_valid & (~disp_valid | ~disp_stall);
  assign tick_stall = s1_valid & ~advance;
  assign tick_take  = tick_valid & ~tick_stall;

  mcud_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // state update runs once per word, as it leaves the input register
  mcud_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .count_down (s1_count_down),
    .cfg        (cfg),
    .result     (result)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (tick_take) begin
      s1_count_down <= count_down;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_valid <= 1'b0;
    end else if (advance) begin
      disp_valid <= 1'b1;
    end else if (!disp_stall) begin
      disp_valid <= 1'b0;
    end
  end

  // result register payload, held while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      tens_enable  <= result.tens_enable;
      units_enable <= result.units_enable;
      segments     <= result.segments;
      bcd_leds     <= result.bcd_leds;
    end
  end

endmodule

### sim/mcud_display_checker.sv
// checker for the counter display: predicts each display word from the tick words
`timescale 1ns / 100ps
module mcud_display_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mcud_pkg::IDX_W-1:0]    cfg_index,
  input  logic [mcud_pkg::TICK_W-1:0]   cfg_data,
  input  logic                          tick_valid,
  input  logic                          tick_stall,
  input  logic                          count_down,
  input  logic                          disp_valid,
  input  logic                          disp_stall,
  input  logic                          tens_enable,
  input  logic                          units_enable,
  input  logic [mcud_pkg::SEG_W-1:0]    segments,
  input  logic [mcud_pkg::BCD_W-1:0]    bcd_leds,
  output int                            mismatch_count,
  output int                            words_pending
);

  localparam int REPORT_LIMIT = 10;

  // segment patterns g..a for digits 0..9
  localparam logic [mcud_pkg::SEG_W-1:0] DIGIT_SEGS [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  // register copy
  logic [mcud_pkg::TICK_W-1:0] up_len, down_len, blink_len;
  logic [mcud_pkg::TICK_W-1:0] over_on, over_wrap_lim, under_on, under_wrap_lim;

  // predicted counter state
  logic [mcud_pkg::CNT_W-1:0]  count_q;
  mcud_pkg::phase_t            phase_q;
  logic [10:0]                 tick_cnt;
  logic [mcud_pkg::TICK_W-1:0] blink_pos;
  logic                        dir_q;
  logic                        digit_q;
  logic [mcud_pkg::BCD_W-1:0]  leds_q;

  mcud_pkg::result_t expected_words[$];

  function automatic logic [mcud_pkg::BCD_W-1:0] led_byte(
    input logic [mcud_pkg::CNT_W-1:0] v);
    logic [mcud_pkg::CNT_W-1:0] t;
    logic [mcud_pkg::CNT_W-1:0] u;
    t = v / mcud_pkg::CNT_W'(10);
    u = v % mcud_pkg::CNT_W'(10);
    return {t[3:0], u[3:0]};
  endfunction

  // drive one digit (or none) and flip the digit select
  task automatic put_digit(input logic on, inout mcud_pkg::result_t w);
    logic [mcud_pkg::BCD_W-1:0] b;
    b = led_byte(count_q);
    w.tens_enable  = 1'b0;
    w.units_enable = 1'b0;
    w.segments     = '0;
    if (on) begin
      if (!digit_q) begin
        w.tens_enable = 1'b1;
        w.segments    = DIGIT_SEGS[b[7:4]];
      end else begin
        w.units_enable = 1'b1;
        w.segments     = DIGIT_SEGS[b[3:0]];
      end
    end
    digit_q = ~digit_q;
  endtask

  task automatic advance_display(input logic dn, output mcud_pkg::result_t w);
    logic                        over;
    logic [mcud_pkg::TICK_W-1:0] on_lim;
    logic [mcud_pkg::TICK_W-1:0] wrap_lim;
    logic [mcud_pkg::TICK_W-1:0] len;
    logic [10:0]                 nxt_pos;
    w = '0;
    if (phase_q == mcud_pkg::PH_OVER || phase_q == mcud_pkg::PH_UNDER) begin
      over     = (phase_q == mcud_pkg::PH_OVER);
      on_lim   = over ? over_on : under_on;
      wrap_lim = over ? over_wrap_lim : under_wrap_lim;
      put_digit(blink_pos < on_lim, w);
      nxt_pos = {1'b0, blink_pos} + 11'd1;
      if (nxt_pos > {1'b0, wrap_lim}) begin
        nxt_pos = '0;
      end
      blink_pos = nxt_pos[mcud_pkg::TICK_W-1:0];
      tick_cnt  = tick_cnt + 11'd1;
      if (tick_cnt >= {1'b0, blink_len}) begin
        count_q  = over ? '0 : mcud_pkg::CNT_W'(mcud_pkg::MAX_COUNT);
        leds_q   = led_byte(count_q);
        phase_q  = mcud_pkg::PH_COUNT;
        tick_cnt = '0;
      end
    end else begin
      phase_q = mcud_pkg::PH_COUNT;
      if (tick_cnt == 0) begin
        dir_q = dn;
      end
      put_digit(1'b1, w);
      tick_cnt = tick_cnt + 11'd1;
      len = dir_q ? down_len : up_len;
      if (tick_cnt >= {1'b0, len}) begin
        tick_cnt = '0;
        if (!dir_q) begin
          if (count_q >= mcud_pkg::CNT_W'(mcud_pkg::MAX_COUNT)) begin
            count_q   = mcud_pkg::CNT_W'(mcud_pkg::MAX_COUNT);
            phase_q   = mcud_pkg::PH_OVER;
            blink_pos = '0;
          end else begin
            count_q = count_q + 1'b1;
          end
        end else begin
          if (count_q == 0) begin
            phase_q   = mcud_pkg::PH_UNDER;
            blink_pos = '0;
          end else begin
            count_q = count_q - 1'b1;
          end
        end
        if (phase_q == mcud_pkg::PH_COUNT) begin
          leds_q = led_byte(count_q);
        end
      end
    end
    w.bcd_leds = leds_q;
  endtask

  always @(posedge clk) begin : watch
    mcud_pkg::result_t want;
    mcud_pkg::result_t got;
    if (rst) begin
      up_len         = mcud_pkg::UP_TICKS_RST;
      down_len       = mcud_pkg::DOWN_TICKS_RST;
      blink_len      = mcud_pkg::BLINK_TICKS_RST;
      over_on        = mcud_pkg::OVER_ON_TICKS_RST;
      over_wrap_lim  = mcud_pkg::OVER_WRAP_RST;
      under_on       = mcud_pkg::UNDER_ON_TICKS_RST;
      under_wrap_lim = mcud_pkg::UNDER_WRAP_RST;
      count_q        = '0;
      phase_q        = mcud_pkg::PH_COUNT;
      tick_cnt       = '0;
      blink_pos      = '0;
      dir_q          = 1'b0;
      digit_q        = 1'b0;
      leds_q         = '0;
      mismatch_count = 0;
      expected_words.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mcud_pkg::CFG_UP_TICKS:       up_len = cfg_data;
          mcud_pkg::CFG_DOWN_TICKS:     down_len = cfg_data;
          mcud_pkg::CFG_BLINK_TICKS:    blink_len = cfg_data;
          mcud_pkg::CFG_OVER_ON_TICKS:  over_on = cfg_data;
          mcud_pkg::CFG_OVER_WRAP:      over_wrap_lim = cfg_data;
          mcud_pkg::CFG_UNDER_ON_TICKS: under_on = cfg_data;
          mcud_pkg::CFG_UNDER_WRAP:     under_wrap_lim = cfg_data;
          default: ;
        endcase
      end
      if (tick_valid && !tick_stall) begin
        advance_display(count_down, want);
        expected_words.push_back(want);
      end
      if (disp_valid && !disp_stall) begin
        got = {tens_enable, units_enable, segments, bcd_leds};
        if (expected_words.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: display word with nothing expected: tens %b units %b seg %h leds %h",
                     $time, got.tens_enable, got.units_enable, got.segments, got.bcd_leds);
          end
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.tens_enable !== want.tens_enable || got.units_enable !== want.units_enable ||
              got.segments !== want.segments || got.bcd_leds !== want.bcd_leds) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("%0t: display mismatch: tens %b/%b units %b/%b seg %h/%h leds %h/%h",
                       $time, want.tens_enable, got.tens_enable, want.units_enable,
                       got.units_enable, want.segments, got.segments, want.bcd_leds,
                       got.bcd_leds);
            end
            mismatch_count++;
          end
        end
      end
    end
    words_pending = expected_words.size();
  end

endmodule

### sim/tb_top.sv
// top of the testbench for the mod-60 counter display: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_top;

  // index with no register behind it, writes there must be ignored
  localparam logic [mcud_pkg::IDX_W-1:0]  CFG_NO_REG = 3'd7;
  localparam logic [mcud_pkg::TICK_W-1:0] TICK_MAX   = 10'd1023;

  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 146;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 8;

  logic                        clk;
  logic                        rst          = 1'b1;
  logic                        cfg_write    = 1'b0;
  logic [mcud_pkg::IDX_W-1:0]  cfg_index    = '0;
  logic [mcud_pkg::TICK_W-1:0] cfg_data     = '0;
  logic                        tick_valid   = 1'b0;
  logic                        tick_stall;
  logic                        count_down   = 1'b0;
  logic                        disp_valid;
  logic                        disp_stall   = 1'b0;
  logic                        tens_enable;
  logic                        units_enable;
  logic [mcud_pkg::SEG_W-1:0]  segments;
  logic [mcud_pkg::BCD_W-1:0]  bcd_leds;

  // idle rates in percent for the tick sender and the display receiver
  int send_idle_pct = 24;
  int recv_idle_pct = 83;

  int mismatch_count;
  int words_pending;

  mod60_updown_counter_display_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .count_down   (count_down),
    .disp_valid   (disp_valid),
    .disp_stall   (disp_stall),
    .tens_enable  (tens_enable),
    .units_enable (units_enable),
    .segments     (segments),
    .bcd_leds     (bcd_leds)
  );

  mcud_display_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .tick_valid     (tick_valid),
    .tick_stall     (tick_stall),
    .count_down     (count_down),
    .disp_valid     (disp_valid),
    .disp_stall     (disp_stall),
    .tens_enable    (tens_enable),
    .units_enable   (units_enable),
    .segments       (segments),
    .bcd_leds       (bcd_leds),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // display side stalls at random, new decision every falling edge
  always @(negedge clk) begin
    disp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #4_800_000;
    $display("FAIL");
    $finish;
  end

  // one tick word: random gaps first, then hold until the block takes it
  task automatic send_tick(input logic dn);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(negedge clk);
    end
    tick_valid <= 1'b1;
    count_down <= dn;
    @(posedge clk);
    while (tick_stall) begin
      @(posedge clk);
    end
  endtask

  // drop valid and wait until every display word has come back
  task automatic wait_idle();
    @(negedge clk);
    tick_valid <= 1'b0;
    while (words_pending != 0) begin
      @(negedge clk);
    end
  endtask

  // single-cycle register write
  task automatic write_reg(input logic [mcud_pkg::IDX_W-1:0] idx,
                           input logic [mcud_pkg::TICK_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // period lengths: mostly short so the count reaches both ends, sometimes zero or huge
  function automatic logic [mcud_pkg::TICK_W-1:0] pick_len(input int unsigned short_max);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return TICK_MAX;
    if (r < 15) return mcud_pkg::TICK_W'($urandom_range(1023));
    return mcud_pkg::TICK_W'($urandom_range(short_max, 1));
  endfunction

  // blink on and wrap thresholds
  function automatic logic [mcud_pkg::TICK_W-1:0] pick_blink_lim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return TICK_MAX;
    if (r < 25) return mcud_pkg::TICK_W'($urandom_range(1023));
    return mcud_pkg::TICK_W'($urandom_range(10));
  endfunction

  initial begin : stimulus
    logic [mcud_pkg::TICK_W-1:0] up_v, down_v, blink_v, oon_v, owrap_v, uon_v, uwrap_v;
    logic dir_run;
    logic dn;
    int   run_left;
    int   wait_cnt;

    dir_run  = 1'b0;
    run_left = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed part ---

    // a few ticks into an up period with the reset settings
    repeat (3) send_tick(1'b0);
    wait_idle();
    // period shortened below the ticks already counted: ends on the next tick
    write_reg(mcud_pkg::CFG_UP_TICKS, 10'd2);
    send_tick(1'b0);
    wait_idle();

    // short periods, zero up length acts as one, blank overflow blink
    write_reg(mcud_pkg::CFG_UP_TICKS, 10'd0);
    write_reg(mcud_pkg::CFG_DOWN_TICKS, 10'd1);
    write_reg(mcud_pkg::CFG_BLINK_TICKS, 10'd3);
    write_reg(mcud_pkg::CFG_OVER_ON_TICKS, 10'd0);
    write_reg(mcud_pkg::CFG_OVER_WRAP, TICK_MAX);
    write_reg(mcud_pkg::CFG_UNDER_ON_TICKS, 10'd1);
    write_reg(mcud_pkg::CFG_UNDER_WRAP, 10'd1);
    write_reg(CFG_NO_REG, TICK_MAX);

    // 1 -> 0, then underflow, blink, load 59
    repeat (5) send_tick(1'b1);
    // 59 stepping up overflows, blank blink, load 0
    repeat (4) send_tick(1'b0);
    wait_idle();

    // zero blink length acts as one tick
    write_reg(mcud_pkg::CFG_BLINK_TICKS, 10'd0);
    repeat (2) send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    wait_idle();

    // --- random part ---
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      unique case (p / 4)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      up_v    = pick_len(4);
      down_v  = pick_len(4);
      blink_v = pick_len(12);
      oon_v   = pick_blink_lim();
      owrap_v = pick_blink_lim();
      uon_v   = pick_blink_lim();
      uwrap_v = pick_blink_lim();
      // fixed extremes on two phases so they are always reached
      if (p == 2) begin
        up_v    = 10'd1;
        down_v  = 10'd1;
        blink_v = 10'd12;
        oon_v   = TICK_MAX;
        owrap_v = TICK_MAX;
        uon_v   = TICK_MAX;
        uwrap_v = TICK_MAX;
      end else if (p == 6) begin
        up_v    = TICK_MAX;
        down_v  = 10'd1;
        blink_v = 10'd1;
        oon_v   = '0;
        owrap_v = '0;
        uon_v   = '0;
        uwrap_v = '0;
      end

      // all registers rewritten while nothing is in flight
      wait_idle();
      write_reg(mcud_pkg::CFG_UP_TICKS, up_v);
      write_reg(mcud_pkg::CFG_DOWN_TICKS, down_v);
      write_reg(mcud_pkg::CFG_BLINK_TICKS, blink_v);
      write_reg(mcud_pkg::CFG_OVER_ON_TICKS, oon_v);
      write_reg(mcud_pkg::CFG_OVER_WRAP, owrap_v);
      write_reg(mcud_pkg::CFG_UNDER_ON_TICKS, uon_v);
      write_reg(mcud_pkg::CFG_UNDER_WRAP, uwrap_v);

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // long runs in one direction so the count reaches both ends,
        // with some single-tick noise on top
        if (run_left == 0) begin
          dir_run  = 1'($urandom_range(1));
          run_left = int'($urandom_range(120, 1));
        end
        run_left--;
        if ($urandom_range(99) < 10) begin
          dn = 1'($urandom_range(1));
        end else begin
          dn = dir_run;
        end
        send_tick(dn);
      end
    end

    // drain: every expected word back, then a settling wait
    @(negedge clk);
    tick_valid <= 1'b0;
    wait_cnt = 0;
    while (words_pending != 0 && wait_cnt < DRAIN_LIMIT) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
